/* hdl/lkvt_pkg.sv */
// Shared types and operation codes for the linear key/value table.
// No dependencies; used by lkvt_cell and linear_key_value_table_top.
package lkvt_pkg;

    // Width of the action field of a request.
    localparam int ACTION_BITS = 2;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_SET    = 2'd0,
        ACT_GET    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    // Control part of the token that walks down the cell chain.
    typedef struct packed {
        logic    valid;
        action_t action;
        logic    found;
    } tok_ctrl_t;

endpackage

/* hdl/lkvt_cell.sv */
// One slot of the key/value table plus its stage of the token chain.
// Depends on lkvt_pkg for the action codes and the token control struct.
module lkvt_cell #(
    parameter int WORD_BITS = 64,
    parameter int INDEX     = 0,
    parameter int CW        = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CW-1:0]         count,
    input  lkvt_pkg::tok_ctrl_t   ctrl_in,
    input  logic [WORD_BITS-1:0]  key_up,
    input  logic [WORD_BITS-1:0]  data_up,
    input  logic [WORD_BITS-1:0]  carry_up,
    output lkvt_pkg::tok_ctrl_t   ctrl_out,
    output logic [WORD_BITS-1:0]  key_down,
    output logic [WORD_BITS-1:0]  data_down,
    output logic [WORD_BITS-1:0]  carry_down
);

    localparam logic [CW-1:0] MY_SLOT  = CW'(INDEX);
    localparam logic [CW-1:0] NEXT_CNT = CW'(INDEX + 1);

    logic [WORD_BITS-1:0] key_reg, key_next;
    logic [WORD_BITS-1:0] val_reg, val_next;

    lkvt_pkg::tok_ctrl_t  ctrl_reg, ctrl_next;
    logic [WORD_BITS-1:0] tkey_reg, tdata_reg, tdata_next;
    logic [WORD_BITS-1:0] tcarry_reg, tcarry_next;

    logic occupied;
    logic is_last;
    logic hit;

    assign occupied = (MY_SLOT < count);
    assign is_last  = (count == NEXT_CNT);
    assign hit      = ctrl_in.valid && occupied && (key_reg == key_up);

    always_comb
    begin
        key_next    = key_reg;
        val_next    = val_reg;
        ctrl_next   = ctrl_in;
        tdata_next  = data_up;
        tcarry_next = carry_up;
        case (ctrl_in.action)
            lkvt_pkg::ACT_SET:
            begin
                if (hit)
                begin
                    val_next        = data_up;
                    ctrl_next.found = 1'b1;
                end
                else if (ctrl_in.valid && count == MY_SLOT)
                begin
                    // first free slot: write ahead, kept only if no hit follows
                    key_next = key_up;
                    val_next = data_up;
                end
            end
            lkvt_pkg::ACT_GET:
            begin
                if (hit)
                begin
                    ctrl_next.found = 1'b1;
                    tdata_next      = val_reg;
                end
            end
            lkvt_pkg::ACT_REMOVE:
            begin
                if (hit)
                begin
                    ctrl_next.found = 1'b1;
                    if (!is_last)
                    begin
                        // fill the hole with the last pair picked up earlier
                        key_next = carry_up;
                        val_next = data_up;
                    end
                end
                else if (ctrl_in.valid && is_last)
                begin
                    tcarry_next = key_reg;
                    tdata_next  = val_reg;
                end
            end
            default:
            begin
                ctrl_next = ctrl_in;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        val_reg    <= val_next;
        tkey_reg   <= key_up;
        tdata_reg  <= tdata_next;
        tcarry_reg <= tcarry_next;
    end

    assign ctrl_out   = ctrl_reg;
    assign key_down   = tkey_reg;
    assign data_down  = tdata_reg;
    assign carry_down = tcarry_reg;

endmodule

/* hdl/linear_key_value_table_top.sv */
// Top level of the linear key/value table: request capture, cell chain,
// result stage and output register. Depends on lkvt_pkg and lkvt_cell.
//
// Usage:
//   Requests arrive on in_valid/in_stall with action, key_in and value_in.
//   Action 0 sets a value, 1 gets it, 2 removes the key, 3 clears the table.
//   Each request yields one result on out_valid/out_stall carrying found,
//   value_out, table_full and entry_count.
//   A request enters a capture register, then walks the chain of CAPACITY
//   cells from the highest slot down to slot 0, one cell per cycle. Each
//   cell compares its stored key and updates itself locally; remove picks
//   up the last pair on the way down and drops it into the matching slot.
//   From cell 0 the result passes the result stage, then the output register.
//   One request is in flight at a time; a new request is taken only once
//   the result reaches the output register, so no new request enters while
//   one is still walking through the cell chain or the result stage.
//   If the receiver stalls, the result holds in the output register and a
//   following result waits in the result stage; input stalls meanwhile.
//   Reset empties the table (pair count zero) and drops any request in
//   flight; no clearing pass is needed. Slot contents are left as they are.
module linear_key_value_table_top #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [63:0] key_in,
    input  logic [63:0] value_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [63:0] value_out,
    output logic        table_full,
    output logic [4:0]  entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    // Token wires: index CAPACITY is the capture register, index i the
    // output of cell i.
    lkvt_pkg::tok_ctrl_t  ctrl_w  [CAPACITY+1];
    logic [WORD_BITS-1:0] key_w   [CAPACITY+1];
    logic [WORD_BITS-1:0] data_w  [CAPACITY+1];
    logic [WORD_BITS-1:0] carry_w [CAPACITY+1];

    logic                 busy_reg;
    logic [CW-1:0]        count_reg, count_next;

    lkvt_pkg::tok_ctrl_t  head_ctrl_reg;
    logic [WORD_BITS-1:0] head_key_reg, head_data_reg;

    logic                 end_valid_reg;
    logic                 end_found_reg, end_full_reg;
    logic [WORD_BITS-1:0] end_value_reg;
    logic [CW-1:0]        end_count_reg;

    logic                 out_valid_reg;
    logic                 out_found_reg, out_full_reg;
    logic [63:0]          out_value_reg;
    logic [4:0]           out_count_reg;

    logic                 in_accept;
    logic                 out_accept;
    logic                 out_load;
    logic                 tok_done;
    logic                 res_full;
    logic [WORD_BITS-1:0] res_value;

    assign in_stall   = busy_reg;
    assign in_accept  = in_valid && !busy_reg;
    assign out_accept = out_valid_reg && !out_stall;
    assign out_load   = end_valid_reg && (!out_valid_reg || !out_stall);
    assign tok_done   = ctrl_w[0].valid;

    // Capture the request; only one token is ever in the chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_ctrl_reg <= '0;
        end
        else
        begin
            head_ctrl_reg.valid  <= in_accept;
            head_ctrl_reg.action <= lkvt_pkg::action_t'(action);
            head_ctrl_reg.found  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            head_key_reg  <= key_in[WORD_BITS-1:0];
            head_data_reg <= value_in[WORD_BITS-1:0];
        end
    end

    assign ctrl_w[CAPACITY]  = head_ctrl_reg;
    assign key_w[CAPACITY]   = head_key_reg;
    assign data_w[CAPACITY]  = head_data_reg;
    assign carry_w[CAPACITY] = head_key_reg;

    // Cell chain: the token walks from the top slot down to slot 0.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        lkvt_cell #(
            .WORD_BITS (WORD_BITS),
            .INDEX     (i),
            .CW        (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .count      (count_reg),
            .ctrl_in    (ctrl_w[i+1]),
            .key_up     (key_w[i+1]),
            .data_up    (data_w[i+1]),
            .carry_up   (carry_w[i+1]),
            .ctrl_out   (ctrl_w[i]),
            .key_down   (key_w[i]),
            .data_down  (data_w[i]),
            .carry_down (carry_w[i])
        );
    end

    // Resolve the result and the new pair count as the token leaves slot 0.
    always_comb
    begin
        count_next = count_reg;
        res_full   = 1'b0;
        res_value  = '0;
        case (ctrl_w[0].action)
            lkvt_pkg::ACT_SET:
            begin
                if (!ctrl_w[0].found)
                begin
                    if (count_reg < FULL_CNT)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        res_full = 1'b1;
                    end
                end
            end
            lkvt_pkg::ACT_GET:
            begin
                if (ctrl_w[0].found)
                begin
                    res_value = data_w[0];
                end
            end
            lkvt_pkg::ACT_REMOVE:
            begin
                if (ctrl_w[0].found)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            end_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // hold input off from accept until the result reaches the output
            if (in_accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (out_load)
            begin
                busy_reg <= 1'b0;
            end

            if (tok_done)
            begin
                count_reg     <= count_next;
                end_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                end_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_accept)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_done)
        begin
            end_found_reg <= ctrl_w[0].found;
            end_full_reg  <= res_full;
            end_value_reg <= res_value;
            end_count_reg <= count_next;
        end
        if (out_load)
        begin
            out_found_reg <= end_found_reg;
            out_full_reg  <= end_full_reg;
            out_value_reg <= 64'(end_value_reg);
            out_count_reg <= 5'(end_count_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign value_out   = out_value_reg;
    assign table_full  = out_full_reg;
    assign entry_count = out_count_reg;

    // Checks on the chain and the result stage.
    logic [CAPACITY:0] chain_valid;

    for (genvar j = 0; j <= CAPACITY; j++)
    begin : g_chain_valid
        assign chain_valid[j] = ctrl_w[j].valid;
    end

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({chain_valid, end_valid_reg}))
        else $error("more than one request in flight");

    a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> (chain_valid == '0) && !end_valid_reg)
        else $error("request accepted while another is in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("pair count above capacity");

    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        end_valid_reg |-> !(end_full_reg && end_found_reg))
        else $error("refused set reported as found");

endmodule
